[hdl/ppc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and width helpers for the 4D projection core.
// No dependencies.
package ppc_pkg;

   localparam int CoordWidthDef = 16;
   localparam int LaneW         = 16;
   localparam int Lanes         = 4;
   localparam int PlaneW        = 16;
   localparam int FocalW        = 16;
   localparam int AxisShift     = 14;
   localparam int DepthW        = PlaneW + AxisShift;
   localparam int QuotBits      = 23;
   localparam int ScreenW       = 24;
   localparam int DivLat        = QuotBits + 1;
   localparam int CsrIndexW     = 3;
   localparam int CsrDataW      = 64;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_CAMERA_POSITION = 3'd0,
      CSR_FORWARD_AXIS    = 3'd1,
      CSR_IMAGE_X_AXIS    = 3'd2,
      CSR_IMAGE_Y_AXIS    = 3'd3,
      CSR_IMAGE_Z_AXIS    = 3'd4,
      CSR_NEAR_PLANE      = 3'd5,
      CSR_FAR_PLANE       = 3'd6,
      CSR_FOCAL_LENGTH    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CsrDataW-1:0] camera_position;
      logic [CsrDataW-1:0] forward_axis;
      logic [CsrDataW-1:0] image_x_axis;
      logic [CsrDataW-1:0] image_y_axis;
      logic [CsrDataW-1:0] image_z_axis;
      logic [PlaneW-1:0]   near_plane;
      logic [PlaneW-1:0]   far_plane;
      logic [FocalW-1:0]   focal_length;
   } cfg_type;

   function automatic int rel_width(input int cw);
      return ((cw > LaneW) ? cw : LaneW) + 1;
   endfunction

   function automatic int dot_width(input int cw);
      return rel_width(cw) + LaneW + 2;
   endfunction

   function automatic logic signed [LaneW-1:0] lane_of(input logic [CsrDataW-1:0] r,
                                                       input int i);
      return $signed(r[i*LaneW +: LaneW]);
   endfunction

endpackage

[hdl/ppc_req_if.sv]
`timescale 1ns / 1ps
// Point word channel (valid/ready) for the projection core.
// No dependencies.
interface ppc_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic signed [COORD_WIDTH-1:0] point_w;
   modport source (output valid, point_x, point_y, point_z, point_w, input ready);
   modport sink (input valid, point_x, point_y, point_z, point_w, output ready);
endinterface

[hdl/ppc_rsp_if.sv]
`timescale 1ns / 1ps
// Result word channel (valid/ready) for the projection core.
// No dependencies.
interface ppc_rsp_if ();
   logic               valid;
   logic               ready;
   logic               visible;
   logic signed [23:0] screen_x;
   logic signed [23:0] screen_y;
   logic signed [23:0] screen_z;
   logic [15:0]        point_depth;
   modport source (output valid, visible, screen_x, screen_y, screen_z, point_depth,
                   input ready);
   modport sink (input valid, visible, screen_x, screen_y, screen_z, point_depth,
                 output ready);
endinterface

[hdl/ppc_front.sv]
`timescale 1ns / 1ps
// Front end: camera offset, four dot products, depth clipping.
// Depends on ppc_pkg and ppc_req_if.
module ppc_front #(
   parameter int COORD_WIDTH = ppc_pkg::CoordWidthDef,
   parameter int EntryW      = 1
) (
   input  logic            clock,
   input  logic            reset,
   ppc_req_if.sink         req_chan,
   input  ppc_pkg::cfg_type cfg,
   input  logic            q_full,
   output logic            q_push,
   output logic [EntryW-1:0] q_data
);
   import ppc_pkg::*;

   localparam int RelW  = rel_width(COORD_WIDTH);
   localparam int ProdW = RelW + LaneW;
   localparam int DotW  = dot_width(COORD_WIDTH);

   logic                   en;
   logic                   v1_ff, v2_ff, v3_ff;
   logic signed [RelW-1:0] rel_ff [Lanes];
   logic signed [ProdW-1:0] prod_ff [Lanes][Lanes];
   logic signed [DotW-1:0] dot_ff [Lanes];
   logic signed [COORD_WIDTH-1:0] pt [Lanes];
   logic [CsrDataW-1:0]    axis [Lanes];
   logic signed [DotW-1:0] lo, hi;
   logic                   vis;
   logic [DotW-1:0]        mag [3];
   logic [2:0]             neg;

   assign en = !v3_ff || !q_full;
   assign req_chan.ready = en;
   assign q_push = v3_ff && !q_full;

   assign pt[0] = req_chan.point_x;
   assign pt[1] = req_chan.point_y;
   assign pt[2] = req_chan.point_z;
   assign pt[3] = req_chan.point_w;
   assign axis[0] = cfg.forward_axis;
   assign axis[1] = cfg.image_x_axis;
   assign axis[2] = cfg.image_y_axis;
   assign axis[3] = cfg.image_z_axis;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < Lanes; i++) begin
            rel_ff[i] <= RelW'(pt[i]) - RelW'(lane_of(cfg.camera_position, i));
         end
         for (int a = 0; a < Lanes; a++) begin
            for (int i = 0; i < Lanes; i++) begin
               prod_ff[a][i] <= ProdW'(rel_ff[i] * lane_of(axis[a], i));
            end
         end
         for (int a = 0; a < Lanes; a++) begin
            dot_ff[a] <= DotW'(prod_ff[a][0]) + DotW'(prod_ff[a][1])
                       + DotW'(prod_ff[a][2]) + DotW'(prod_ff[a][3]);
         end
      end
   end

   assign lo  = $signed(DotW'({cfg.near_plane, {AxisShift{1'b0}}}));
   assign hi  = $signed(DotW'({cfg.far_plane, {AxisShift{1'b0}}}));
   assign vis = (dot_ff[0] >= lo) && (dot_ff[0] <= hi);

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         neg[l] = dot_ff[l+1][DotW-1];
         mag[l] = neg[l] ? DotW'(-dot_ff[l+1]) : DotW'(dot_ff[l+1]);
      end
   end

   assign q_data = {vis, neg, dot_ff[0][DepthW-1:0], mag[0], mag[1], mag[2]};
endmodule

[hdl/ppc_queue.sv]
`timescale 1ns / 1ps
// Two-entry word queue between front and back ends.
// Depends on nothing but its parameter.
module ppc_queue #(
   parameter int EntryW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [EntryW-1:0] push_data,
   input  logic              pop,
   output logic [EntryW-1:0] pop_data,
   output logic              full,
   output logic              empty
);
   logic [EntryW-1:0] mem [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

[hdl/ppc_divider.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on ppc_pkg.
module ppc_divider #(
   parameter int NumW = 51
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [NumW-1:0]             num,
   input  logic [ppc_pkg::DepthW-1:0]  den,
   output logic [ppc_pkg::QuotBits-1:0] quot,
   output logic                        sat
);
   import ppc_pkg::*;

   localparam int RemW = DepthW + QuotBits;
   localparam int CmpW = (NumW > RemW) ? NumW : RemW;

   logic [RemW-1:0]     rem_ff [QuotBits+1];
   logic [QuotBits-1:0] q_ff   [QuotBits+1];
   logic [DepthW-1:0]   d_ff   [QuotBits+1];
   logic                sat_ff [QuotBits+1];
   logic [CmpW-1:0]     num_ext, lim;

   assign num_ext = CmpW'(num);
   assign lim     = CmpW'({den, {QuotBits{1'b0}}});

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_ext[RemW-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= den;
         sat_ff[0] <= (num != '0) && (num_ext >= lim);
      end
   end

   for (genvar j = 1; j <= QuotBits; j++) begin : g_stage
      logic [RemW-1:0] trial;
      logic            ge;
      assign trial = {{QuotBits{1'b0}}, d_ff[j-1]} << (QuotBits - j);
      // zero divisor with zero numerator yields a zero quotient
      assign ge    = (d_ff[j-1] != '0) && (rem_ff[j-1] >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? rem_ff[j-1] - trial : rem_ff[j-1];
            q_ff[j]   <= {q_ff[j-1][QuotBits-2:0], ge};
            d_ff[j]   <= d_ff[j-1];
            sat_ff[j] <= sat_ff[j-1];
         end
      end
   end

   assign quot = q_ff[QuotBits];
   assign sat  = sat_ff[QuotBits];
endmodule

[hdl/ppc_back.sv]
`timescale 1ns / 1ps
// Back end: focal scaling, three divider lanes, saturation and result register.
// Depends on ppc_pkg, ppc_divider and ppc_rsp_if.
module ppc_back #(
   parameter int COORD_WIDTH = ppc_pkg::CoordWidthDef,
   parameter int EntryW      = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ppc_pkg::FocalW-1:0] focal_length,
   input  logic [EntryW-1:0]         q_data,
   input  logic                      q_empty,
   output logic                      q_pop,
   ppc_rsp_if.source                 rsp_chan
);
   import ppc_pkg::*;

   localparam int MagW = dot_width(COORD_WIDTH);
   localparam int HiW  = MagW - 32;
   localparam int NumW = MagW + FocalW;
   localparam int Meta = 2 + DivLat;

   logic                en;
   logic                vis_in;
   logic [2:0]          neg_in;
   logic [DepthW-1:0]   d_in;
   logic [MagW-1:0]     mag_in [3];
   logic [Meta-1:0]     vld_ff;
   logic                vis_ff [Meta];
   logic [2:0]          neg_ff [Meta];
   logic [PlaneW-1:0]   dep_ff [Meta];
   logic [DepthW-1:0]   d1_ff, d2_ff;
   logic [31+FocalW:0]  pl_ff [3];
   logic [HiW+FocalW-1:0] ph_ff [3];
   logic [NumW-1:0]     n_ff [3];
   logic [QuotBits-1:0] quot [3];
   logic                sat [3];
   logic [ScreenW-1:0]  scr [3];
   logic                out_v_ff;
   logic                out_vis_ff;
   logic [ScreenW-1:0]  out_scr_ff [3];
   logic [PlaneW-1:0]   out_dep_ff;

   assign {vis_in, neg_in, d_in, mag_in[0], mag_in[1], mag_in[2]} = q_data;
   assign en    = !out_v_ff || rsp_chan.ready;
   assign q_pop = en && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         vld_ff   <= {vld_ff[Meta-2:0], !q_empty};
         out_v_ff <= vld_ff[Meta-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vis_ff[0] <= vis_in;
         neg_ff[0] <= neg_in;
         dep_ff[0] <= d_in[DepthW-1:AxisShift];
         for (int k = 1; k < Meta; k++) begin
            vis_ff[k] <= vis_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            dep_ff[k] <= dep_ff[k-1];
         end
         d1_ff <= d_in;
         d2_ff <= d1_ff;
         for (int l = 0; l < 3; l++) begin
            pl_ff[l] <= mag_in[l][31:0] * focal_length;
            ph_ff[l] <= mag_in[l][MagW-1:32] * focal_length;
            n_ff[l]  <= NumW'({ph_ff[l], 32'b0}) + NumW'(pl_ff[l]);
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      ppc_divider #(.NumW(NumW)) u_div (
         .clock (clock),
         .en    (en),
         .num   (n_ff[l]),
         .den   (d2_ff),
         .quot  (quot[l]),
         .sat   (sat[l])
      );
      always_comb begin
         if (sat[l]) begin
            scr[l] = neg_ff[Meta-1][l] ? {1'b1, {(ScreenW-1){1'b0}}}
                                       : {1'b0, {(ScreenW-1){1'b1}}};
         end else if (neg_ff[Meta-1][l]) begin
            scr[l] = -{1'b0, quot[l]};
         end else begin
            scr[l] = {1'b0, quot[l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_vis_ff <= vis_ff[Meta-1];
         out_dep_ff <= vis_ff[Meta-1] ? dep_ff[Meta-1] : '0;
         for (int l = 0; l < 3; l++) begin
            out_scr_ff[l] <= vis_ff[Meta-1] ? scr[l] : '0;
         end
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.visible     = out_vis_ff;
   assign rsp_chan.screen_x    = out_scr_ff[0];
   assign rsp_chan.screen_y    = out_scr_ff[1];
   assign rsp_chan.screen_z    = out_scr_ff[2];
   assign rsp_chan.point_depth = out_dep_ff;
endmodule

[hdl/perspective_projection_4d_core.sv]
`timescale 1ns / 1ps
// 4D perspective projection core: registers, front end, queue, back end.
// Depends on ppc_pkg, ppc_req_if, ppc_rsp_if, ppc_front, ppc_queue, ppc_back.
//
// Usage: points arrive on req_chan (valid/ready), one word per 4D point.
// Results leave on rsp_chan, one word per point, in order.
// Camera, axes, planes and focal length are written through csr_we /
// csr_index / csr_wdata while the core is idle; 16-bit registers take the
// low bits of csr_wdata.
// Throughput: one point per cycle unless stalled. Path: offset, product and
// dot-product registers, queue, focal product and sum registers, 24 divider
// stages (input stage, then one quotient bit per stage), result register.
// Reset: synchronous, clears pipeline valids and the queue and loads the
// register defaults (near 26, far 65535, focal 256, others 0).
// Stall: when rsp_chan.ready is low the back end holds; the front end keeps
// taking points until the two-entry queue fills, then drops req ready.
module perspective_projection_4d_core #(
   parameter int COORD_WIDTH = ppc_pkg::CoordWidthDef
) (
   input  logic                            clock,
   input  logic                            reset,
   ppc_req_if.sink                         req_chan,
   ppc_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [ppc_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [ppc_pkg::CsrDataW-1:0]    csr_wdata
);
   import ppc_pkg::*;

   localparam int EntryW = 1 + 3 + DepthW + 3 * dot_width(COORD_WIDTH);

   cfg_type           cfg_ff;
   logic              q_push, q_pop, q_full, q_empty;
   logic [EntryW-1:0] q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_position <= '0;
         cfg_ff.forward_axis    <= '0;
         cfg_ff.image_x_axis    <= '0;
         cfg_ff.image_y_axis    <= '0;
         cfg_ff.image_z_axis    <= '0;
         cfg_ff.near_plane      <= PlaneW'(26);
         cfg_ff.far_plane       <= '1;
         cfg_ff.focal_length    <= FocalW'(256);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAMERA_POSITION: cfg_ff.camera_position <= csr_wdata;
            CSR_FORWARD_AXIS:    cfg_ff.forward_axis    <= csr_wdata;
            CSR_IMAGE_X_AXIS:    cfg_ff.image_x_axis    <= csr_wdata;
            CSR_IMAGE_Y_AXIS:    cfg_ff.image_y_axis    <= csr_wdata;
            CSR_IMAGE_Z_AXIS:    cfg_ff.image_z_axis    <= csr_wdata;
            CSR_NEAR_PLANE:      cfg_ff.near_plane      <= csr_wdata[PlaneW-1:0];
            CSR_FAR_PLANE:       cfg_ff.far_plane       <= csr_wdata[PlaneW-1:0];
            CSR_FOCAL_LENGTH:    cfg_ff.focal_length    <= csr_wdata[FocalW-1:0];
            default: ;
         endcase
      end
   end

   ppc_front #(.COORD_WIDTH(COORD_WIDTH), .EntryW(EntryW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   ppc_queue #(.EntryW(EntryW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   ppc_back #(.COORD_WIDTH(COORD_WIDTH), .EntryW(EntryW)) u_back (
      .clock        (clock),
      .reset        (reset),
      .focal_length (cfg_ff.focal_length),
      .q_data       (q_out),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_chan     (rsp_chan)
   );
endmodule
